// File: sv/c2fw_pkg.sv
// Shared types and constants for the Cartesian to fractional wrap unit.
package c2fw_pkg;

    // Width of the exact cofactor sums, determinant and numerators.
    localparam int NW = 100;
    // Restoring division steps: integer part of the numerator plus 32 fraction bits.
    localparam int DIV_STEPS = NW + 32;
    localparam int DIM = 3;

    typedef logic signed [31:0] elem_t;
    typedef logic signed [NW-1:0] wide_t;
    typedef logic signed [64:0] cof_t;

    typedef struct packed {
        logic mac_start;
        logic div_start;
    } lane_ctrl_t;

    typedef struct packed {
        logic mac_done;
        logic div_done;
    } lane_stat_t;

    function automatic logic signed [32:0] sx33(input elem_t e);
        return {e[31], e};
    endfunction

endpackage

// File: sv/c2fw_mac.sv
// Per-lane cofactor, numerator and determinant accumulator on one shared multiplier.
module c2fw_mac (
    input  logic                                clk,
    input  logic                                rst_n,
    input  c2fw_pkg::lane_ctrl_t                ctrl,
    input  c2fw_pkg::elem_t [2:0]               row_own,
    input  c2fw_pkg::elem_t [2:0]               row_p1,
    input  c2fw_pkg::elem_t [2:0]               row_p2,
    input  c2fw_pkg::elem_t [2:0]               coord,
    output c2fw_pkg::wide_t                     num,
    output c2fw_pkg::wide_t                     det,
    output logic                                done
);

    localparam logic [4:0] MAC_LAST = 5'd17;

    logic [4:0]              step_reg;
    logic                    busy_reg;
    logic                    pv_reg;
    logic [4:0]              tgt_reg;
    logic signed [65:0]      prod_reg;
    c2fw_pkg::cof_t [2:0]    cof_reg;
    c2fw_pkg::wide_t         num_reg;
    c2fw_pkg::wide_t         det_reg;
    logic                    done_reg;

    logic signed [32:0]      opa;
    logic signed [32:0]      opb;
    logic signed [65:0]      prod_next;
    c2fw_pkg::wide_t         ext;
    c2fw_pkg::wide_t         ext_sh;

    function automatic logic signed [32:0] hi33(input c2fw_pkg::cof_t c);
        return c[64:32];
    endfunction

    function automatic logic signed [32:0] lo33(input c2fw_pkg::cof_t c);
        return {1'b0, c[31:0]};
    endfunction

    // Steps 0-5 form the cofactors, 6-11 the numerator, 12-17 the determinant.
    always_comb
    begin
        opa = '0;
        opb = '0;
        case (step_reg)
            5'd0:  begin opa = c2fw_pkg::sx33(row_p1[1]); opb = c2fw_pkg::sx33(row_p2[2]); end
            5'd1:  begin opa = c2fw_pkg::sx33(row_p1[2]); opb = c2fw_pkg::sx33(row_p2[1]); end
            5'd2:  begin opa = c2fw_pkg::sx33(row_p1[2]); opb = c2fw_pkg::sx33(row_p2[0]); end
            5'd3:  begin opa = c2fw_pkg::sx33(row_p1[0]); opb = c2fw_pkg::sx33(row_p2[2]); end
            5'd4:  begin opa = c2fw_pkg::sx33(row_p1[0]); opb = c2fw_pkg::sx33(row_p2[1]); end
            5'd5:  begin opa = c2fw_pkg::sx33(row_p1[1]); opb = c2fw_pkg::sx33(row_p2[0]); end
            5'd6:  begin opa = c2fw_pkg::sx33(coord[0]); opb = lo33(cof_reg[0]); end
            5'd7:  begin opa = c2fw_pkg::sx33(coord[0]); opb = hi33(cof_reg[0]); end
            5'd8:  begin opa = c2fw_pkg::sx33(coord[1]); opb = lo33(cof_reg[1]); end
            5'd9:  begin opa = c2fw_pkg::sx33(coord[1]); opb = hi33(cof_reg[1]); end
            5'd10: begin opa = c2fw_pkg::sx33(coord[2]); opb = lo33(cof_reg[2]); end
            5'd11: begin opa = c2fw_pkg::sx33(coord[2]); opb = hi33(cof_reg[2]); end
            5'd12: begin opa = c2fw_pkg::sx33(row_own[0]); opb = lo33(cof_reg[0]); end
            5'd13: begin opa = c2fw_pkg::sx33(row_own[0]); opb = hi33(cof_reg[0]); end
            5'd14: begin opa = c2fw_pkg::sx33(row_own[1]); opb = lo33(cof_reg[1]); end
            5'd15: begin opa = c2fw_pkg::sx33(row_own[1]); opb = hi33(cof_reg[1]); end
            5'd16: begin opa = c2fw_pkg::sx33(row_own[2]); opb = lo33(cof_reg[2]); end
            5'd17: begin opa = c2fw_pkg::sx33(row_own[2]); opb = hi33(cof_reg[2]); end
            default: begin opa = '0; opb = '0; end
        endcase
    end

    assign prod_next = opa * opb;
    assign ext       = {{(c2fw_pkg::NW-66){prod_reg[65]}}, prod_reg};
    assign ext_sh    = {ext[c2fw_pkg::NW-33:0], 32'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            pv_reg   <= 1'b0;
            tgt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            pv_reg   <= busy_reg;
            tgt_reg  <= step_reg;
            done_reg <= pv_reg && (tgt_reg == MAC_LAST);
            if (ctrl.mac_start)
            begin
                step_reg <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 5'd1;
                if (step_reg == MAC_LAST)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (ctrl.mac_start)
        begin
            num_reg <= '0;
            det_reg <= '0;
        end
        else if (pv_reg)
        begin
            case (tgt_reg)
                5'd0:  cof_reg[0] <= prod_reg[64:0];
                5'd1:  cof_reg[0] <= cof_reg[0] - prod_reg[64:0];
                5'd2:  cof_reg[1] <= prod_reg[64:0];
                5'd3:  cof_reg[1] <= cof_reg[1] - prod_reg[64:0];
                5'd4:  cof_reg[2] <= prod_reg[64:0];
                5'd5:  cof_reg[2] <= cof_reg[2] - prod_reg[64:0];
                5'd6, 5'd8, 5'd10:   num_reg <= num_reg + ext;
                5'd7, 5'd9, 5'd11:   num_reg <= num_reg + ext_sh;
                5'd12, 5'd14, 5'd16: det_reg <= det_reg + ext;
                5'd13, 5'd15, 5'd17: det_reg <= det_reg + ext_sh;
                default: num_reg <= num_reg;
            endcase
        end
    end

    assign num  = num_reg;
    assign det  = det_reg;
    assign done = done_reg;

endmodule

// File: sv/c2fw_div.sv
// Per-lane restoring divider giving the low 32 bits of the floored quotient.
module c2fw_div (
    input  logic                    clk,
    input  logic                    rst_n,
    input  c2fw_pkg::lane_ctrl_t    ctrl,
    input  c2fw_pkg::wide_t         num,
    input  c2fw_pkg::wide_t         det,
    output logic [31:0]             frac,
    output logic                    done
);

    localparam int DW = c2fw_pkg::NW;

    logic [7:0]         cnt_reg;
    logic               busy_reg;
    logic               fin_reg;
    logic               neg_reg;
    logic [DW+31:0]     dvd_reg;
    logic [DW-1:0]      dsr_reg;
    logic [DW-1:0]      rem_reg;
    logic [31:0]        q_reg;

    logic [DW:0]        trial;
    logic [DW:0]        diff;
    logic               ge;
    logic [DW-1:0]      num_abs;
    logic [DW-1:0]      det_abs;
    logic [31:0]        q_adj;

    assign num_abs = num[DW-1] ? DW'(-num) : DW'(num);
    assign det_abs = det[DW-1] ? DW'(-det) : DW'(det);
    assign trial   = {rem_reg, dvd_reg[DW+31]};
    assign diff    = trial - {1'b0, dsr_reg};
    assign ge      = !diff[DW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
        end
        else
        begin
            fin_reg <= 1'b0;
            if (ctrl.div_start)
            begin
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 8'd1;
                if (cnt_reg == 8'(c2fw_pkg::DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.div_start)
        begin
            neg_reg <= num[DW-1] ^ det[DW-1];
            dvd_reg <= {num_abs, 32'b0};
            dsr_reg <= det_abs;
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DW+30:0], 1'b0};
            rem_reg <= ge ? diff[DW-1:0] : trial[DW-1:0];
            q_reg   <= {q_reg[30:0], ge};
        end
    end

    // A negative quotient floors away from zero when the remainder is not zero.
    assign q_adj = q_reg + {31'b0, |rem_reg};
    assign frac  = neg_reg ? (~q_adj + 32'd1) : q_reg;
    assign done  = fin_reg;

endmodule

// File: sv/cartesian_to_fractional_wrap_unit.sv
// Top level of the Cartesian to fractional coordinate unit with wrap into the unit cell.
//
// The unit holds a 3x3 lattice matrix, rows being the lattice vectors, written one
// element per request of kind 0 (a request with row or col of 3 writes nothing and
// gives no result). A request of kind 1 carries a Cartesian position in signed
// Q16.16 and yields one result: the fractional coordinates, each wrapped into [0,1)
// as unsigned Q0.32, computed exactly from the cofactors and the determinant.
// Three identical lanes, one per output component, each own a single 33x33
// multiplier and a restoring divider. A lane first forms its row of cofactors, its
// numerator and a Laplace expansion of the determinant on the shared multiplier,
// the merging logic takes the determinant from the first lane and checks it for
// zero, then all lanes divide together, one quotient bit per cycle over 132 bits.
// A singular lattice skips the division and returns zeros with the singular flag.
// Requests are taken one conversion at a time, but a new request may be accepted
// while the previous result still waits in the output register.
module cartesian_to_fractional_wrap_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                kind,
    input  logic [1:0]          row,
    input  logic [1:0]          col,
    input  logic signed [31:0]  element_value,
    input  logic signed [31:0]  coord_x,
    input  logic signed [31:0]  coord_y,
    input  logic signed [31:0]  coord_z,
    input  logic                last_atom,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [31:0]         frac_a,
    output logic [31:0]         frac_b,
    output logic [31:0]         frac_c,
    output logic                singular,
    output logic                end_of_batch
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MAC   = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0]                 state_reg;
    logic [2:0]                 state_next;
    c2fw_pkg::elem_t [8:0]      mat_reg;
    c2fw_pkg::elem_t [2:0]      x_reg;
    logic                       last_reg;
    c2fw_pkg::wide_t            det_reg;
    logic                       sing_reg;
    logic [31:0]                res_reg [3];
    logic                       out_valid_reg;
    logic [31:0]                out_a_reg;
    logic [31:0]                out_b_reg;
    logic [31:0]                out_c_reg;
    logic                       out_sing_reg;
    logic                       out_eob_reg;

    logic                       in_fire;
    logic                       out_load;
    logic [3:0]                 ld_idx;
    c2fw_pkg::lane_ctrl_t       ctrl;
    c2fw_pkg::lane_stat_t       stat [3];
    c2fw_pkg::wide_t            lane_num [3];
    c2fw_pkg::wide_t            lane_det [3];
    logic [31:0]                lane_frac [3];

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || out_ready);

    // Row-major position of the element that a load request writes.
    assign ld_idx = ({2'b0, row} * 4'd3) + {2'b0, col};

    assign ctrl.mac_start = in_fire && kind;
    assign ctrl.div_start = (state_reg == S_CHECK) && (det_reg != '0);

    // Lane i expands along lattice row i; its cofactors come from the two rows after it.
    for (genvar i = 0; i < c2fw_pkg::DIM; i++)
    begin : g_lane
        localparam int R1 = (i + 1) % c2fw_pkg::DIM;
        localparam int R2 = (i + 2) % c2fw_pkg::DIM;

        c2fw_mac u_mac (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (ctrl),
            .row_own ({mat_reg[i*3+2],  mat_reg[i*3+1],  mat_reg[i*3]}),
            .row_p1  ({mat_reg[R1*3+2], mat_reg[R1*3+1], mat_reg[R1*3]}),
            .row_p2  ({mat_reg[R2*3+2], mat_reg[R2*3+1], mat_reg[R2*3]}),
            .coord   (x_reg),
            .num     (lane_num[i]),
            .det     (lane_det[i]),
            .done    (stat[i].mac_done)
        );

        c2fw_div u_div (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (ctrl),
            .num   (lane_num[i]),
            .det   (det_reg),
            .frac  (lane_frac[i]),
            .done  (stat[i].div_done)
        );
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_fire && kind) state_next = S_MAC;
            S_MAC:   if (stat[0].mac_done) state_next = S_CHECK;
            S_CHECK: state_next = (det_reg == '0) ? S_OUT : S_DIV;
            S_DIV:   if (stat[0].div_done) state_next = S_OUT;
            S_OUT:   if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mat_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_fire && !kind && (row != 2'd3) && (col != 2'd3))
            begin
                mat_reg[ld_idx] <= element_value;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && kind)
        begin
            x_reg    <= {coord_z, coord_y, coord_x};
            last_reg <= last_atom;
        end
        if ((state_reg == S_MAC) && stat[0].mac_done)
        begin
            det_reg <= lane_det[0];
        end
        if (state_reg == S_CHECK)
        begin
            sing_reg <= (det_reg == '0);
            res_reg  <= '{32'd0, 32'd0, 32'd0};
        end
        if ((state_reg == S_DIV) && stat[0].div_done)
        begin
            res_reg <= lane_frac;
        end
        if (out_load)
        begin
            out_a_reg    <= res_reg[0];
            out_b_reg    <= res_reg[1];
            out_c_reg    <= res_reg[2];
            out_sing_reg <= sing_reg;
            out_eob_reg  <= last_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign frac_a       = out_a_reg;
    assign frac_b       = out_b_reg;
    assign frac_c       = out_c_reg;
    assign singular     = out_sing_reg;
    assign end_of_batch = out_eob_reg;

`ifndef ASSERT_OFF
    a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && singular |-> (frac_a == 32'd0) && (frac_b == 32'd0) && (frac_c == 32'd0))
        else $error("singular result carries non-zero coordinates");

    a_mac_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        (stat[0].mac_done == stat[1].mac_done) && (stat[0].mac_done == stat[2].mac_done))
        else $error("lane accumulators out of step");

    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        (stat[0].div_done == stat[1].div_done) && (stat[0].div_done == stat[2].div_done))
        else $error("lane dividers out of step");

    a_sing_det: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT) && sing_reg |-> (det_reg == '0))
        else $error("singular flag with non-zero determinant");

    a_div_after_check: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.div_start |=> (state_reg == S_DIV))
        else $error("division started outside the check step");
`endif

endmodule
